// ===== sv/bbpie_pkg.sv =====
// Package: shared types, constants and the Bernstein weight function for the patch evaluator.
package bbpie_pkg;

   localparam int unsigned WEIGHT_WIDTH = 17;   // unsigned Q1.16
   localparam int unsigned PATCH_WIDTH  = 3;
   localparam int unsigned CFG_WIDTH    = 3;

   typedef enum logic {
      REQ_LOAD = 1'b0,
      REQ_EVAL = 1'b1
   } req_kind_type;

   typedef enum logic {
      CSR_PATCHES_U = 1'b0,
      CSR_PATCHES_V = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      BACK_IDLE  = 2'd0,
      BACK_ACCUM = 2'd1,
      BACK_DRAIN = 2'd2,
      BACK_OUT   = 2'd3
   } back_state_type;

   // Bernstein weight k at parameter s/n, Q1.16 rounded half up.
   // Evaluated on constant arguments only (elaboration-time tables);
   // the quotient is formed bit by bit.
   function automatic logic [WEIGHT_WIDTH-1:0] bern_q16(input int unsigned k,
                                                         input int unsigned s,
                                                         input int unsigned n);
      longint unsigned num;
      longint unsigned den;
      longint unsigned b;
      longint unsigned dvd;
      longint unsigned quo;
      longint unsigned rem;
      b = (k == 0 || k == 3) ? 1 : 3;
      num = b;
      den = longint'(n) * n * n;
      for (int i = 0; i < 3; i++) begin
         if (i < k) num = num * s;
         else num = num * (n - s);
      end
      dvd = (num << 16) + (den >> 1);
      quo = 64'd0;
      rem = 64'd0;
      for (int i = 63; i >= 0; i--) begin
         rem = (rem << 1) | ((dvd >> i) & 64'd1);
         if (rem >= den) begin
            rem = rem - den;
            quo = quo | (64'd1 << i);
         end
      end
      bern_q16 = WEIGHT_WIDTH'(quo);
   endfunction

endpackage

// ===== sv/bbpie_if.sv =====
// Interfaces: valid/ready channel carrying one request or one response item.
interface bbpie_req_if #(parameter int unsigned COORD_WIDTH = 32);
   logic                   valid;
   logic                   ready;
   logic                   req_type;
   logic [3:0]             net_row;
   logic [3:0]             net_col;
   logic [COORD_WIDTH-1:0] coord_x;
   logic [COORD_WIDTH-1:0] coord_y;
   logic [COORD_WIDTH-1:0] coord_z;
   logic [2:0]             patch_row;
   logic [2:0]             patch_col;
   logic                   direction;
   logic [1:0]             line_index;
   logic [3:0]             sample_index;
   modport source (output valid, req_type, net_row, net_col, coord_x, coord_y, coord_z,
                   patch_row, patch_col, direction, line_index, sample_index,
                   input ready);
   modport sink   (input valid, req_type, net_row, net_col, coord_x, coord_y, coord_z,
                   patch_row, patch_col, direction, line_index, sample_index,
                   output ready);
endinterface

interface bbpie_rsp_if #(parameter int unsigned COORD_WIDTH = 32);
   logic                   valid;
   logic                   ready;
   logic [COORD_WIDTH-1:0] point_x;
   logic [COORD_WIDTH-1:0] point_y;
   logic [COORD_WIDTH-1:0] point_z;
   logic                   range_error;
   modport source (output valid, point_x, point_y, point_z, range_error, input ready);
   modport sink   (input valid, point_x, point_y, point_z, range_error, output ready);
endinterface

// ===== sv/bicubic_bezier_patch_isoline_eval_core.sv =====
// Top level: bicubic Bezier patch isoline evaluator with control-net memories.
//
// Usage:
//  - req channel carries one item per handshake: a load (req_type 0) writes one net
//    point at (net_row, net_col); an evaluate (req_type 1) returns one surface point.
//  - rsp channel carries one item per evaluate: point_x/y/z in signed Q16.16,
//    range_error set (and zero point) when the patch lies outside the configured net.
//  - csr port: csr_we, csr_index, csr_wdata; index 0 patches_u, index 1 patches_v.
//    Write only while the block is idle.
//  - Front end computes Bernstein weights from constant tables and range-checks,
//    then pushes a command into a two-entry queue; back end runs the work.
//  - Back end: a load writes its net point straight from the queue head; an
//    out-of-range evaluate only loads the output register. An evaluate makes 16
//    memory reads (one control point per cycle from the net RAM), drains the
//    read/weight/multiply/accumulate pipe, then loads the output register.
//  - Reset clears the control state and the registers to one patch each way;
//    net memories are undefined until written and get no clearing pass.
//  - When rsp stalls, the finished item waits in the output register; the next
//    evaluate runs up to its output cycle and holds there with its command at the
//    queue head, so one more item is accepted before req.ready drops.
module bicubic_bezier_patch_isoline_eval_core
   import bbpie_pkg::*;
#(
   parameter int unsigned NET_SIDE    = 16,
   parameter int unsigned SEGMENTS    = 10,
   parameter int unsigned COORD_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   bbpie_req_if.sink             req,
   bbpie_rsp_if.source           rsp,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CFG_WIDTH-1:0]  csr_wdata
);
   localparam int unsigned ROW_WIDTH = $clog2(NET_SIDE);
   localparam int unsigned CMD_WIDTH = 1 + 2*ROW_WIDTH + 3*COORD_WIDTH + 2*WEIGHT_WIDTH*4 + 1;

   logic [CFG_WIDTH-1:0] patches_u_ff, patches_v_ff;
   logic                 cmd_valid, cmd_ready;
   logic [CMD_WIDTH-1:0] cmd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         patches_u_ff <= CFG_WIDTH'(1);
         patches_v_ff <= CFG_WIDTH'(1);
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_PATCHES_U: patches_u_ff <= csr_wdata;
            CSR_PATCHES_V: patches_v_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   bbpie_front #(
      .NET_SIDE(NET_SIDE), .SEGMENTS(SEGMENTS), .COORD_WIDTH(COORD_WIDTH),
      .ROW_WIDTH(ROW_WIDTH), .CMD_WIDTH(CMD_WIDTH)
   ) u_front (
      .clock, .reset, .req,
      .patches_u(patches_u_ff), .patches_v(patches_v_ff),
      .cmd_valid, .cmd_ready, .cmd_data
   );

   bbpie_back #(
      .NET_SIDE(NET_SIDE), .COORD_WIDTH(COORD_WIDTH),
      .ROW_WIDTH(ROW_WIDTH), .CMD_WIDTH(CMD_WIDTH)
   ) u_back (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd_data, .rsp
   );

   a_cfg_nonzero_reset: assert property (@(posedge clock)
      $past(reset) |-> patches_u_ff == CFG_WIDTH'(1) && patches_v_ff == CFG_WIDTH'(1))
      else $error("config not reset");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.point_x))
      else $error("response dropped while stalled");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.range_error |-> rsp.point_x == '0 && rsp.point_z == '0)
      else $error("error item has nonzero point");
endmodule

// ===== sv/bbpie_front.sv =====
// Front end: accepts items, classifies load/evaluate, range-checks, and queues commands.
module bbpie_front
   import bbpie_pkg::*;
#(
   parameter int unsigned NET_SIDE    = 16,
   parameter int unsigned SEGMENTS    = 10,
   parameter int unsigned COORD_WIDTH = 32,
   parameter int unsigned ROW_WIDTH   = $clog2(NET_SIDE),
   parameter int unsigned CMD_WIDTH   = 1 + 2*ROW_WIDTH + 3*COORD_WIDTH + 2*WEIGHT_WIDTH*4 + 1
) (
   input  logic                  clock,
   input  logic                  reset,
   bbpie_req_if.sink             req,
   input  logic [CFG_WIDTH-1:0]  patches_u,
   input  logic [CFG_WIDTH-1:0]  patches_v,
   output logic                  cmd_valid,
   input  logic                  cmd_ready,
   output logic [CMD_WIDTH-1:0]  cmd_data
);
   // command layout: {kind, row, col, x, y, z, wa[3:0], wb[3:0], err}
   localparam int unsigned SEG_W = $clog2(SEGMENTS + 1);
   localparam int unsigned DEPTH = 2;

   logic [CMD_WIDTH-1:0] q_ff [DEPTH];
   logic [CMD_WIDTH-1:0] q_in;
   logic                 wp_ff, rp_ff;
   logic [1:0]           cnt_ff;
   logic                 push, pop;

   logic [WEIGHT_WIDTH-1:0] sw [4];
   logic [WEIGHT_WIDTH-1:0] lw [4];
   logic [WEIGHT_WIDTH-1:0] wa [4];
   logic [WEIGHT_WIDTH-1:0] wb [4];
   logic [SEG_W-1:0]        samp;
   logic                    err;
   logic                    load_ok;
   logic [ROW_WIDTH-1:0]    row, col;
   logic [5:0]              base_r, base_c;

   always_comb begin
      samp = (32'(req.sample_index) > SEGMENTS) ? SEG_W'(SEGMENTS) : SEG_W'(req.sample_index);
      for (int k = 0; k < 4; k++) begin
         sw[k] = '0;
         for (int s = 0; s <= SEGMENTS; s++)
            if (32'(samp) == s) sw[k] = bern_q16(k, s, SEGMENTS);
         lw[k] = '0;
         for (int l = 0; l < 4; l++)
            if (32'(req.line_index) == l) lw[k] = bern_q16(k, l, 3);
         wa[k] = req.direction ? sw[k] : lw[k];
         wb[k] = req.direction ? lw[k] : sw[k];
      end
      base_r = 6'(req.patch_row) * 6'd3;
      base_c = 6'(req.patch_col) * 6'd3;
      err = (req.patch_row >= patches_u) || (req.patch_col >= patches_v)
         || (32'(base_r) + 3 >= NET_SIDE) || (32'(base_c) + 3 >= NET_SIDE);
      load_ok = (32'(req.net_row) < NET_SIDE) && (32'(req.net_col) < NET_SIDE);
      if (req.req_type == REQ_LOAD) begin
         row = ROW_WIDTH'(req.net_row);
         col = ROW_WIDTH'(req.net_col);
      end else begin
         row = ROW_WIDTH'(base_r);
         col = ROW_WIDTH'(base_c);
      end
      q_in = {req.req_type, row, col, req.coord_x, req.coord_y, req.coord_z,
              wa[3], wa[2], wa[1], wa[0], wb[3], wb[2], wb[1], wb[0],
              (req.req_type == REQ_LOAD) ? !load_ok : err};
   end

   assign req.ready = (cnt_ff != 2'(DEPTH));
   assign push      = req.valid && req.ready;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd_data  = q_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= q_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop)  rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'(DEPTH))
      else $error("queue count overflow");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'(DEPTH) |-> !push) else $error("push into full queue");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> cnt_ff != 2'd0) else $error("pop from empty queue");
endmodule

// ===== sv/bbpie_back.sv =====
// Back end: net memories, 16-step multiply-accumulate and rounding/saturation.
module bbpie_back
   import bbpie_pkg::*;
#(
   parameter int unsigned NET_SIDE    = 16,
   parameter int unsigned COORD_WIDTH = 32,
   parameter int unsigned ROW_WIDTH   = $clog2(NET_SIDE),
   parameter int unsigned CMD_WIDTH   = 1 + 2*ROW_WIDTH + 3*COORD_WIDTH + 2*WEIGHT_WIDTH*4 + 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   output logic                 cmd_ready,
   input  logic [CMD_WIDTH-1:0] cmd_data,
   bbpie_rsp_if.source          rsp
);
   localparam int unsigned AW    = 2 * ROW_WIDTH;
   localparam int unsigned DEPTH = 1 << AW;
   localparam int unsigned PW    = COORD_WIDTH + WEIGHT_WIDTH + 1;
   localparam int unsigned ACC_W = PW + 5;

   logic [COORD_WIDTH-1:0] mem_x [DEPTH];
   logic [COORD_WIDTH-1:0] mem_y [DEPTH];
   logic [COORD_WIDTH-1:0] mem_z [DEPTH];

   logic                   c_kind, c_err;
   logic [ROW_WIDTH-1:0]   c_row, c_col;
   logic [COORD_WIDTH-1:0] c_x, c_y, c_z;
   logic [WEIGHT_WIDTH-1:0] c_wa [4];
   logic [WEIGHT_WIDTH-1:0] c_wb [4];

   assign {c_kind, c_row, c_col, c_x, c_y, c_z,
           c_wa[3], c_wa[2], c_wa[1], c_wa[0],
           c_wb[3], c_wb[2], c_wb[1], c_wb[0], c_err} = cmd_data;

   back_state_type state_ff, state_in;
   logic [3:0]  step_ff, step_in;
   logic        rd_v_ff, rd_v_in;          // read data valid this cycle
   logic        wv_ff;                     // product valid this cycle
   logic        pv_ff;                     // accumulator updated last cycle
   logic [COORD_WIDTH-1:0] rdx_ff, rdy_ff, rdz_ff;
   logic [WEIGHT_WIDTH-1:0] w_ff;
   logic [2*WEIGHT_WIDTH-1:0] wprod;
   logic signed [PW-1:0]    px_ff, py_ff, pz_ff;
   logic signed [ACC_W-1:0] ax_ff, ay_ff, az_ff;
   logic [COORD_WIDTH-1:0]  ox_ff, oy_ff, oz_ff;
   logic                    oerr_ff;
   logic                    start, finish_eval;
   logic [AW-1:0]           rd_addr;
   logic [ROW_WIDTH-1:0]    rr, rc;

   function automatic logic [COORD_WIDTH-1:0] sat_round(input logic signed [ACC_W-1:0] a);
      logic signed [ACC_W-1:0] r;
      logic signed [ACC_W-1:0] hi, lo;
      r  = (a + ACC_W'(32768)) >>> 16;
      hi = ACC_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 1);
      lo = -hi - 1;
      if (r > hi) r = hi;
      if (r < lo) r = lo;
      return r[COORD_WIDTH-1:0];
   endfunction

   always_comb begin
      rr = c_row + ROW_WIDTH'(step_ff[3:2]);
      rc = c_col + ROW_WIDTH'(step_ff[1:0]);
      rd_addr = {rr, rc};
   end

   // in-range loads write straight from the queue head
   always_ff @(posedge clock) begin
      if (cmd_valid && cmd_ready && c_kind == REQ_LOAD && !c_err) begin
         mem_x[{c_row, c_col}] <= c_x;
         mem_y[{c_row, c_col}] <= c_y;
         mem_z[{c_row, c_col}] <= c_z;
      end
      rdx_ff <= mem_x[rd_addr];
      rdy_ff <= mem_y[rd_addr];
      rdz_ff <= mem_z[rd_addr];
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      rd_v_in  = 1'b0;
      cmd_ready = 1'b0;
      start = 1'b0;
      finish_eval = 1'b0;
      unique case (state_ff)
         BACK_IDLE: begin
            if (cmd_valid) begin
               if (c_kind == REQ_LOAD) begin
                  cmd_ready = 1'b1;
               end else if (c_err) begin
                  if (!rsp.valid || rsp.ready) begin
                     cmd_ready = 1'b1;
                     finish_eval = 1'b1;
                  end
               end else begin
                  start    = 1'b1;
                  rd_v_in  = 1'b1;
                  step_in  = 4'd1;
                  state_in = BACK_ACCUM;
               end
            end
         end
         BACK_ACCUM: begin
            rd_v_in = 1'b1;
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd15) state_in = BACK_DRAIN;
         end
         BACK_DRAIN: begin
            if (!rd_v_ff && !wv_ff && !pv_ff) state_in = BACK_OUT;
         end
         BACK_OUT: begin
            if (!rsp.valid || rsp.ready) begin
               cmd_ready   = 1'b1;
               finish_eval = 1'b1;
               step_in     = 4'd0;
               state_in    = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   assign wprod = c_wa[step_ff[3:2]] * c_wb[step_ff[1:0]];

   always_ff @(posedge clock) begin
      // weight of the term fetched this cycle, aligned with read data
      w_ff  <= WEIGHT_WIDTH'((wprod + (2*WEIGHT_WIDTH)'(32768)) >> 16);
      px_ff <= PW'($signed(rdx_ff)) * $signed({1'b0, w_ff});
      py_ff <= PW'($signed(rdy_ff)) * $signed({1'b0, w_ff});
      pz_ff <= PW'($signed(rdz_ff)) * $signed({1'b0, w_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
         step_ff  <= 4'd0;
         rd_v_ff  <= 1'b0;
         wv_ff    <= 1'b0;
         pv_ff    <= 1'b0;
         rsp.valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         rd_v_ff  <= rd_v_in;
         wv_ff    <= rd_v_ff;
         pv_ff    <= wv_ff;
         if (finish_eval) rsp.valid <= 1'b1;
         else if (rsp.ready) rsp.valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         ax_ff <= '0;
         ay_ff <= '0;
         az_ff <= '0;
      end else if (wv_ff) begin
         ax_ff <= ax_ff + ACC_W'(px_ff);
         ay_ff <= ay_ff + ACC_W'(py_ff);
         az_ff <= az_ff + ACC_W'(pz_ff);
      end
      if (finish_eval) begin
         oerr_ff <= c_err;
         ox_ff <= c_err ? '0 : sat_round(ax_ff);
         oy_ff <= c_err ? '0 : sat_round(ay_ff);
         oz_ff <= c_err ? '0 : sat_round(az_ff);
      end
   end

   assign rsp.point_x     = ox_ff;
   assign rsp.point_y     = oy_ff;
   assign rsp.point_z     = oz_ff;
   assign rsp.range_error = oerr_ff;

   a_drain_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == BACK_OUT |-> !rd_v_ff && !wv_ff && !pv_ff)
      else $error("pipeline busy at output");
   a_accum_steps: assert property (@(posedge clock) disable iff (reset)
      state_ff == BACK_ACCUM && step_ff == 4'd15 |=> state_ff == BACK_DRAIN)
      else $error("accumulate step count wrong");
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == BACK_IDLE |-> !rd_v_ff && !wv_ff && !pv_ff)
      else $error("idle with pending products");
endmodule
